[rtl/lru_cache_count_cost_limit_core_assert.svh]
// Assertion macros for the cache core
`ifndef LRU_CACHE_COUNT_COST_LIMIT_CORE_ASSERT_SVH
`define LRU_CACHE_COUNT_COST_LIMIT_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LRUCC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lrucc assertion failed");

// condition holds on every clock out of reset
`define LRUCC_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lrucc assertion failed");

`endif

[rtl/lrucc_pkg.sv]
package lrucc_pkg;

	localparam int VAL_W  = 32;
	localparam int COST_W = 16;
	localparam int TOT_W  = 20;
	localparam int CL_W   = 5;
	localparam int ACT_W  = 3;

	localparam logic [ACT_W-1:0] ACT_GET      = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SET      = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CONTAIN  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd4;

	localparam logic REG_COUNT_LIMIT = 1'b0;
	localparam logic REG_COST_LIMIT  = 1'b1;

	localparam logic [CL_W-1:0]  COUNT_LIMIT_RST = 5'd16;
	localparam logic [TOT_W-1:0] TOT_MAX         = '1;

	// recency order commands, at most one per cycle
	typedef struct packed {
		logic touch;
		logic drop;
		logic insert;
		logic clear;
	} ord_cmd_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_DECIDE = 7'b0000100,
		ST_EVICT  = 7'b0001000,
		ST_INSERT = 7'b0010000,
		ST_TRIM   = 7'b0100000,
		ST_FINAL  = 7'b1000000
	} state_t;

	// saturating add of a cost to the total
	function automatic logic [TOT_W-1:0] tot_add(input logic [TOT_W-1:0] t,
		input logic [COST_W-1:0] c);
		logic [TOT_W:0] s;
		s = {1'b0, t} + {{(TOT_W+1-COST_W){1'b0}}, c};
		return s[TOT_W] ? TOT_MAX : s[TOT_W-1:0];
	endfunction

	// subtract a cost, clamped at zero
	function automatic logic [TOT_W-1:0] tot_sub(input logic [TOT_W-1:0] t,
		input logic [COST_W-1:0] c);
		logic [TOT_W-1:0] cx;
		cx = {{(TOT_W-COST_W){1'b0}}, c};
		return (t > cx) ? (t - cx) : '0;
	endfunction

endpackage

[rtl/lrucc_req_if.sv]
interface lrucc_req_if #(parameter int KEY_BITS = 32);
	logic                               valid;
	logic                               ready;
	logic [lrucc_pkg::ACT_W-1:0]        action;
	logic [KEY_BITS-1:0]                key;
	logic [lrucc_pkg::VAL_W-1:0]        value_handle;
	logic [lrucc_pkg::COST_W-1:0]       cost;

	modport source (output valid, action, key, value_handle, cost, input ready);
	modport sink (input valid, action, key, value_handle, cost, output ready);
endinterface

[rtl/lrucc_rsp_if.sv]
interface lrucc_rsp_if #(parameter int KEY_BITS = 32);
	logic                               valid;
	logic                               ready;
	logic                               is_eviction;
	logic                               hit;
	logic [KEY_BITS-1:0]                out_key;
	logic [lrucc_pkg::VAL_W-1:0]        out_value;
	logic [lrucc_pkg::COST_W-1:0]       out_cost;
	logic                               last;

	modport source (output valid, is_eviction, hit, out_key, out_value, out_cost, last,
		input ready);
	modport sink (input valid, is_eviction, hit, out_key, out_value, out_cost, last,
		output ready);
endinterface

[rtl/lrucc_ram.sv]
module lrucc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/lrucc_order.sv]
// Valid bits and recency ranks, one cell per slot; rank 0 is most recent
module lrucc_order #(
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lrucc_pkg::ord_cmd_t        cmd,
	input  logic [$clog2(ENTRIES)-1:0] slot,
	input  logic [$clog2(ENTRIES)-1:0] rd_idx,
	output logic                       rd_valid,
	output logic [$clog2(ENTRIES)-1:0] rd_rank
);

	localparam int IDX_W = $clog2(ENTRIES);

	logic             valid_q [ENTRIES];
	logic [IDX_W-1:0] rank_q  [ENTRIES];
	logic [IDX_W-1:0] sel_rank;

	assign sel_rank = rank_q[slot];
	assign rd_valid = valid_q[rd_idx];
	assign rd_rank  = rank_q[rd_idx];

	// each cell follows the command against the selected slot's rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (cmd.clear) begin
					valid_q[i] <= 1'b0;
					rank_q[i]  <= '0;
				end else if (cmd.touch) begin
					if (IDX_W'(i) == slot) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && rank_q[i] < sel_rank) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end else if (cmd.drop) begin
					if (IDX_W'(i) == slot) begin
						valid_q[i] <= 1'b0;
						rank_q[i]  <= '0;
					end else if (valid_q[i] && rank_q[i] > sel_rank) begin
						rank_q[i] <= rank_q[i] - 1'b1;
					end
				end else if (cmd.insert) begin
					if (IDX_W'(i) == slot) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end
		end
	end

endmodule

[rtl/lru_cache_count_cost_limit_core.sv]
// Get, contain and remove scan the entry RAM at one read a cycle, then decide and output
// their result; a set also writes the entry on a hit or inserts a new key, first evicting
// the least recent entry when the store is full, then trims by evicting while a limit is
// exceeded; clear and unknown actions go straight to the final result.
// Throughput: one item at a time, the next accepted the cycle after the final result is
// registered; a stalled result holds the sequencer. Reset: all entries invalid, count and
// total cost zero, count limit 16 and cost limit at its maximum.
module lru_cache_count_cost_limit_core #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	lrucc_req_if.sink           req,
	lrucc_rsp_if.source         rsp,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [19:0]         cfg_data
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > lrucc_pkg::CL_W) ? CNT_W : lrucc_pkg::CL_W;
	localparam int WORD_W = KEY_BITS + lrucc_pkg::VAL_W + lrucc_pkg::COST_W;

	lrucc_pkg::state_t state_q;

	logic [lrucc_pkg::ACT_W-1:0]   act_q;
	logic [KEY_BITS-1:0]           key_q;
	logic [lrucc_pkg::VAL_W-1:0]   val_q;
	logic [lrucc_pkg::COST_W-1:0]  cost_q;

	logic [lrucc_pkg::CL_W-1:0]    count_limit_q;
	logic [lrucc_pkg::TOT_W-1:0]   cost_limit_q;
	logic [CNT_W-1:0]              count_q;
	logic [lrucc_pkg::TOT_W-1:0]   total_q;
	logic [CNT_W-1:0]              n_q;

	logic [IDX_W:0]                scan_q;
	logic                          vld_s1;
	logic [IDX_W-1:0]              idx_s1;
	logic                          lru_mode_q;
	logic                          hit_q;
	logic                          free_found_q;
	logic [IDX_W-1:0]              free_q;
	logic [IDX_W-1:0]              slot_q;
	logic                          ins_pend_q;
	logic [KEY_BITS-1:0]           cap_key_q;
	logic [lrucc_pkg::VAL_W-1:0]   cap_val_q;
	logic [lrucc_pkg::COST_W-1:0]  cap_cost_q;

	logic                          out_vld_q;
	logic                          out_ev_q;
	logic                          out_hit_q;
	logic [KEY_BITS-1:0]           out_key_q;
	logic [lrucc_pkg::VAL_W-1:0]   out_val_q;
	logic [lrucc_pkg::COST_W-1:0]  out_cost_q;
	logic                          out_last_q;

	logic                          ram_we;
	logic [WORD_W-1:0]             ram_rdata;
	logic [KEY_BITS-1:0]           rd_key;
	logic [lrucc_pkg::VAL_W-1:0]   rd_val;
	logic [lrucc_pkg::COST_W-1:0]  rd_cost;
	logic                          rd_valid;
	logic [IDX_W-1:0]              rd_rank;
	lrucc_pkg::ord_cmd_t           ord_cmd;
	logic [IDX_W-1:0]              ord_slot;

	logic accept;
	logic can_emit;
	logic out_load;
	logic scan_end;
	logic cnt_over;
	logic cost_over;
	logic trim_room;
	logic is_lookup;
	logic [CNT_W-1:0] cnt_m1;

	assign req.ready = (state_q == lrucc_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign can_emit  = !out_vld_q || rsp.ready;
	assign out_load  = can_emit &&
		((state_q == lrucc_pkg::ST_EVICT) || (state_q == lrucc_pkg::ST_FINAL));
	assign scan_end  = vld_s1 && (idx_s1 == IDX_W'(ENTRIES - 1));
	assign cnt_m1    = count_q - 1'b1;
	assign cnt_over  = CMP_W'(count_q) > CMP_W'(count_limit_q);
	assign cost_over = total_q > cost_limit_q;
	assign trim_room = (count_q != '0) && (n_q < CNT_W'(ENTRIES));
	assign is_lookup = (act_q == lrucc_pkg::ACT_GET) || (act_q == lrucc_pkg::ACT_CONTAIN) ||
		(act_q == lrucc_pkg::ACT_REMOVE);

	assign {rd_key, rd_val, rd_cost} = ram_rdata;

	assign rsp.valid       = out_vld_q;
	assign rsp.is_eviction = out_ev_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.out_key     = out_key_q;
	assign rsp.out_value   = out_val_q;
	assign rsp.out_cost    = out_cost_q;
	assign rsp.last        = out_last_q;

	// entry store: key, value and cost in one word
	lrucc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata ({key_q, val_q, cost_q}),
		.raddr (scan_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	lrucc_order #(
		.ENTRIES (ENTRIES)
	) u_order (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (ord_cmd),
		.slot     (ord_slot),
		.rd_idx   (idx_s1),
		.rd_valid (rd_valid),
		.rd_rank  (rd_rank)
	);

	// RAM writes and recency commands for the current state
	always_comb begin
		ram_we   = 1'b0;
		ord_cmd  = '0;
		ord_slot = slot_q;
		case (state_q)
			lrucc_pkg::ST_IDLE: begin
				if (accept && req.action == lrucc_pkg::ACT_CLEAR) begin
					ord_cmd.clear = 1'b1;
				end
			end
			lrucc_pkg::ST_DECIDE: begin
				if (hit_q) begin
					if (act_q == lrucc_pkg::ACT_SET) begin
						ram_we        = 1'b1;
						ord_cmd.touch = 1'b1;
					end else if (act_q == lrucc_pkg::ACT_GET) begin
						ord_cmd.touch = 1'b1;
					end else if (act_q == lrucc_pkg::ACT_REMOVE) begin
						ord_cmd.drop = 1'b1;
					end
				end
			end
			lrucc_pkg::ST_EVICT: begin
				ord_cmd.drop = can_emit;
			end
			lrucc_pkg::ST_INSERT: begin
				ram_we         = 1'b1;
				ord_cmd.insert = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer, scan pipeline, totals and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lrucc_pkg::ST_IDLE;
			act_q         <= '0;
			key_q         <= '0;
			val_q         <= '0;
			cost_q        <= '0;
			count_limit_q <= lrucc_pkg::COUNT_LIMIT_RST;
			cost_limit_q  <= lrucc_pkg::TOT_MAX;
			count_q       <= '0;
			total_q       <= '0;
			n_q           <= '0;
			scan_q        <= '0;
			vld_s1        <= 1'b0;
			idx_s1        <= '0;
			lru_mode_q    <= 1'b0;
			hit_q         <= 1'b0;
			free_found_q  <= 1'b0;
			free_q        <= '0;
			slot_q        <= '0;
			ins_pend_q    <= 1'b0;
			cap_key_q     <= '0;
			cap_val_q     <= '0;
			cap_cost_q    <= '0;
			out_vld_q     <= 1'b0;
			out_ev_q      <= 1'b0;
			out_hit_q     <= 1'b0;
			out_key_q     <= '0;
			out_val_q     <= '0;
			out_cost_q    <= '0;
			out_last_q    <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				if (cfg_index == lrucc_pkg::REG_COUNT_LIMIT) begin
					count_limit_q <= cfg_data[lrucc_pkg::CL_W-1:0];
				end else begin
					cost_limit_q <= cfg_data;
				end
			end

			// output valid: loaded by evict or final, cleared when taken
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				lrucc_pkg::ST_IDLE: begin
					if (accept) begin
						act_q        <= req.action;
						key_q        <= req.key;
						val_q        <= req.value_handle;
						cost_q       <= req.cost;
						n_q          <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						ins_pend_q   <= 1'b0;
						lru_mode_q   <= 1'b0;
						scan_q       <= '0;
						vld_s1       <= 1'b0;
						if (req.action == lrucc_pkg::ACT_CLEAR) begin
							count_q <= '0;
							total_q <= '0;
							state_q <= lrucc_pkg::ST_FINAL;
						end else if (req.action == lrucc_pkg::ACT_GET ||
							req.action == lrucc_pkg::ACT_SET ||
							req.action == lrucc_pkg::ACT_CONTAIN ||
							req.action == lrucc_pkg::ACT_REMOVE) begin
							state_q <= lrucc_pkg::ST_SCAN;
						end else begin
							state_q <= lrucc_pkg::ST_FINAL;
						end
					end
				end
				lrucc_pkg::ST_SCAN: begin
					// issue one read a cycle
					if (scan_q < (IDX_W + 1)'(ENTRIES)) begin
						scan_q <= scan_q + 1'b1;
						vld_s1 <= 1'b1;
						idx_s1 <= scan_q[IDX_W-1:0];
					end else begin
						vld_s1 <= 1'b0;
					end
					// check the word read last cycle
					if (vld_s1) begin
						if (!lru_mode_q) begin
							if (rd_valid && rd_key == key_q) begin
								hit_q      <= 1'b1;
								slot_q     <= idx_s1;
								cap_key_q  <= rd_key;
								cap_val_q  <= rd_val;
								cap_cost_q <= rd_cost;
							end
							if (!rd_valid && !free_found_q) begin
								free_found_q <= 1'b1;
								free_q       <= idx_s1;
							end
						end else if (rd_valid && CNT_W'(rd_rank) == cnt_m1) begin
							slot_q     <= idx_s1;
							cap_key_q  <= rd_key;
							cap_val_q  <= rd_val;
							cap_cost_q <= rd_cost;
						end
					end
					if (scan_end) begin
						state_q <= lru_mode_q ? lrucc_pkg::ST_EVICT : lrucc_pkg::ST_DECIDE;
					end
				end
				lrucc_pkg::ST_DECIDE: begin
					if (act_q == lrucc_pkg::ACT_SET) begin
						if (hit_q) begin
							total_q <= lrucc_pkg::tot_add(
								lrucc_pkg::tot_sub(total_q, cap_cost_q), cost_q);
							state_q <= lrucc_pkg::ST_TRIM;
						end else if (free_found_q) begin
							slot_q  <= free_q;
							state_q <= lrucc_pkg::ST_INSERT;
						end else begin
							// full: evict the least recent entry first
							ins_pend_q <= 1'b1;
							lru_mode_q <= 1'b1;
							scan_q     <= '0;
							vld_s1     <= 1'b0;
							state_q    <= lrucc_pkg::ST_SCAN;
						end
					end else begin
						if (act_q == lrucc_pkg::ACT_REMOVE && hit_q) begin
							count_q <= count_q - 1'b1;
							total_q <= lrucc_pkg::tot_sub(total_q, cap_cost_q);
						end
						state_q <= lrucc_pkg::ST_FINAL;
					end
				end
				lrucc_pkg::ST_EVICT: begin
					if (can_emit) begin
						out_ev_q   <= 1'b1;
						out_hit_q  <= 1'b0;
						out_key_q  <= cap_key_q;
						out_val_q  <= cap_val_q;
						out_cost_q <= cap_cost_q;
						out_last_q <= 1'b0;
						count_q    <= count_q - 1'b1;
						total_q    <= lrucc_pkg::tot_sub(total_q, cap_cost_q);
						n_q        <= n_q + 1'b1;
						if (ins_pend_q) begin
							ins_pend_q <= 1'b0;
							state_q    <= lrucc_pkg::ST_INSERT;
						end else begin
							state_q <= lrucc_pkg::ST_TRIM;
						end
					end
				end
				lrucc_pkg::ST_INSERT: begin
					count_q <= count_q + 1'b1;
					total_q <= lrucc_pkg::tot_add(total_q, cost_q);
					state_q <= lrucc_pkg::ST_TRIM;
				end
				lrucc_pkg::ST_TRIM: begin
					if ((cnt_over || cost_over) && trim_room) begin
						lru_mode_q <= 1'b1;
						scan_q     <= '0;
						vld_s1     <= 1'b0;
						state_q    <= lrucc_pkg::ST_SCAN;
					end else begin
						state_q <= lrucc_pkg::ST_FINAL;
					end
				end
				lrucc_pkg::ST_FINAL: begin
					if (can_emit) begin
						out_ev_q   <= 1'b0;
						out_hit_q  <= hit_q && is_lookup;
						out_key_q  <= key_q;
						out_last_q <= 1'b1;
						if (act_q == lrucc_pkg::ACT_GET && hit_q) begin
							out_val_q  <= cap_val_q;
							out_cost_q <= cap_cost_q;
						end else begin
							out_val_q  <= '0;
							out_cost_q <= '0;
						end
						state_q <= lrucc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lrucc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	`include "lru_cache_count_cost_limit_core_assert.svh"

	`LRUCC_ASSERT_IMPL(a_evict_not_last, rsp.valid && rsp.is_eviction, !rsp.last && !rsp.hit)
	`LRUCC_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(ENTRIES))
	`LRUCC_ASSERT_ALWAYS(a_one_cmd, $onehot0(ord_cmd))
	`LRUCC_ASSERT_IMPL(a_ram_write_quiet, ram_we, !vld_s1 && state_q != lrucc_pkg::ST_SCAN)

endmodule
